FILE: rtl/brcs_pkg.sv
package brcs_pkg;

  // Field widths of the request and of each piece.
  localparam int unsigned OFF_W      = 48;
  localparam int unsigned LEN_W      = 48;
  localparam int unsigned CHUNK_W    = 31;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned BIT_CNT_W  = 6;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 31'd65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/byte_range_chunk_splitter_core.sv
// After a request is accepted, its start offset is divided by the chunk size bit-serially,
// and then its pieces are loaded into the master-side output register in order.
// A new request is taken only once the last piece of the previous one is in the output
// register, or once an empty range on a chunk boundary has been found to touch no chunk.
// Reset (rst, synchronous, active high) empties the output register, returns the
// sequencer to idle and sets the chunk size register to 65536.
module byte_range_chunk_splitter_core
  import brcs_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: the chunk size in bytes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CHUNK_W-1:0]    cfg_data,
  // Requests.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [47:0] start_offset, [95:48] range_length
  // Pieces.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [47:0] chunk_number, [78:48] offset_in_chunk,
                                                // [109:79] piece_length, [111:110] zero
  output logic                  m_axis_tlast,   // last_piece
  output logic [0:0]            m_axis_tuser    // [0] truncated
);

  localparam int unsigned SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  state_t state, state_next;

  logic [CHUNK_W-1:0]    chunk_bytes;
  logic [BIT_CNT_W-1:0]  bit_cnt, bit_cnt_next;
  // The quotient register first holds the start offset, shifted out from the top one bit
  // per cycle while quotient bits enter at the bottom. During emission it is the
  // chunk number of the next piece.
  logic [OFF_W-1:0]      quo, quo_next;
  logic [CHUNK_W-1:0]    rem, rem_next;
  logic [LEN_W-1:0]      remaining, remaining_next;
  logic [SEG_W-1:0]      seg_cnt, seg_cnt_next;

  logic                  m_valid_next;
  logic [OUT_DATA_W-1:0] m_data_next;
  logic                  m_last_next;
  logic                  m_user_next;

  // Division step and piece arithmetic.
  logic [CHUNK_W-1:0]    csize;
  logic [CHUNK_W:0]      rem_acc;
  logic [CHUNK_W:0]      rem_sub;
  logic                  rem_ge;
  logic [CHUNK_W-1:0]    poff;
  logic [CHUNK_W-1:0]    room;
  logic [CHUNK_W-1:0]    plen;
  logic [LEN_W-1:0]      rem_after;
  logic                  at_limit;
  logic                  fin;
  logic                  cut;
  logic                  out_free;

  // A chunk size of zero behaves as a chunk size of one.
  assign csize = (chunk_bytes == '0) ? CHUNK_W'(1) : chunk_bytes;

  // Restoring division, one quotient bit per cycle. The partial remainder stays below
  // csize, so only the compare and subtract of 32 bits sit in this path.
  assign rem_acc = {rem, quo[OFF_W-1]};
  assign rem_sub = rem_acc - {1'b0, csize};
  assign rem_ge  = (rem_acc >= {1'b0, csize});

  // Only the first piece of a request starts inside its chunk.
  assign poff      = (seg_cnt == '0) ? rem : '0;
  assign room      = csize - poff;
  assign plen      = (remaining < LEN_W'(room)) ? remaining[CHUNK_W-1:0] : room;
  assign rem_after = remaining - LEN_W'(plen);
  assign at_limit  = (seg_cnt == SEG_W'(MAX_SEGMENTS - 1));
  assign fin       = (rem_after == '0) || at_limit;
  assign cut       = (rem_after != '0) && at_limit;

  // The output register can take a new piece when it is empty or being drained.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Configuration must be written only while no request is in flight; the core itself does not enforce this.
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    bit_cnt_next   = bit_cnt;
    quo_next       = quo;
    rem_next       = rem;
    remaining_next = remaining;
    seg_cnt_next   = seg_cnt;
    m_valid_next   = m_axis_tvalid;
    m_data_next    = m_axis_tdata;
    m_last_next    = m_axis_tlast;
    m_user_next    = m_axis_tuser[0];

    if (m_axis_tvalid && m_axis_tready) begin
      m_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          quo_next       = s_axis_tdata[OFF_W-1:0];
          remaining_next = s_axis_tdata[OFF_W+LEN_W-1:OFF_W];
          rem_next       = '0;
          bit_cnt_next   = '0;
          seg_cnt_next   = '0;
          state_next     = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_next     = {quo[OFF_W-2:0], rem_ge};
        rem_next     = rem_ge ? rem_sub[CHUNK_W-1:0] : rem_acc[CHUNK_W-1:0];
        bit_cnt_next = bit_cnt + BIT_CNT_W'(1);
        if (bit_cnt == BIT_CNT_W'(OFF_W - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if ((seg_cnt == '0) && (remaining == '0) && (rem == '0)) begin
          // An empty range on a chunk boundary touches no chunk.
          state_next = ST_IDLE;
        end else if (out_free) begin
          m_valid_next   = 1'b1;
          m_data_next    = OUT_DATA_W'({plen, poff, quo});
          m_last_next    = fin;
          m_user_next    = cut;
          remaining_next = rem_after;
          quo_next       = quo + OFF_W'(1);
          seg_cnt_next   = seg_cnt + SEG_W'(1);
          if (fin) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes   <= CHUNK_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        chunk_bytes <= cfg_data;
      end
      m_axis_tvalid <= m_valid_next;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    bit_cnt         <= bit_cnt_next;
    quo             <= quo_next;
    rem             <= rem_next;
    remaining       <= remaining_next;
    seg_cnt         <= seg_cnt_next;
    m_axis_tdata    <= m_data_next;
    m_axis_tlast    <= m_last_next;
    m_axis_tuser[0] <= m_user_next;
  end

endmodule

FILE: rtl/brcs_checker.sv
module brcs_checker
  import brcs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic [0:0]            m_axis_tuser
);

  // Set while a request has delivered some but not all of its pieces.
  logic mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      mid <= !m_axis_tlast;
    end
  end

  a_trunc_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("truncated flag on a piece that is not the last");

  a_later_offset_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && mid |-> (m_axis_tdata[78:48] == '0))
    else $error("non-zero offset on a piece after the first");

  // Once the last piece sits in the output register the core may already take
  // the next request.
  a_no_accept_mid: assert property (@(posedge clk) disable iff (rst)
    mid && !(m_axis_tvalid && m_axis_tlast) |-> !s_axis_tready)
    else $error("new request accepted while pieces are still due");

  a_inner_piece_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[109:79] != '0))
    else $error("empty piece that is not the last");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled piece changed");

endmodule

bind byte_range_chunk_splitter_core brcs_checker u_brcs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: test/byte_range_chunk_splitter_core_test.sv
`timescale 1ns / 100ps

module byte_range_chunk_splitter_core_test
  import brcs_pkg::*;
();

  localparam int unsigned MAX_SEGMENTS = 64;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam bit [47:0]   OFF_MAX      = 48'hFFFF_FFFF_FFFF;

  // One expected piece of a split request.
  typedef struct {
    bit [47:0] chunk;
    bit [30:0] inset;
    bit [30:0] len;
    bit        last;
    bit        cut;
  } piece_t;

  // Splits each accepted request into the pieces the core should emit and
  // checks the emitted pieces against them in order.
  class piece_ledger;
    piece_t      pending[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned pieces_seen;
    int unsigned cut_requests;
    int unsigned empty_pieces;

    function void note_request(bit [47:0] start, bit [47:0] span, bit [30:0] chunk_reg);
      bit [63:0] size;
      bit [63:0] first;
      bit [63:0] inset;
      bit [63:0] end_chunk;
      bit [63:0] count;
      bit [63:0] left;
      bit [63:0] room;
      bit [63:0] plen;
      bit [63:0] poff;
      bit        cut;
      piece_t    p;
      size      = (chunk_reg == '0) ? 64'd1 : {33'd0, chunk_reg};
      first     = {16'd0, start} / size;
      inset     = {16'd0, start} % size;
      end_chunk = ({16'd0, start} + {16'd0, span} + size - 64'd1) / size;
      count     = end_chunk - first;
      cut       = count > 64'(MAX_SEGMENTS);
      if (cut) begin
        count = 64'(MAX_SEGMENTS);
        cut_requests++;
      end
      left = {16'd0, span};
      requests++;
      for (int k = 0; k < int'(count); k++) begin
        poff    = (k == 0) ? inset : 64'd0;
        room    = size - poff;
        plen    = (left < room) ? left : room;
        left    = left - plen;
        p.chunk = 48'(first + 64'(k));
        p.inset = poff[30:0];
        p.len   = plen[30:0];
        p.last  = (k + 1 == int'(count));
        p.cut   = p.last && cut;
        pending = {pending, p};
      end
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    function void check_piece(bit [OUT_DATA_W-1:0] data, bit last, bit trunc);
      piece_t want;
      pieces_seen++;
      if (data[109:79] == '0) begin
        empty_pieces++;
      end
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: piece with no request behind it: chunk %0d offset %0d len %0d",
                   $realtime, data[47:0], data[78:48], data[109:79]);
        end
        return;
      end
      want = pending.pop_front();
      if (data[47:0] != want.chunk || data[78:48] != want.inset ||
          data[109:79] != want.len || data[111:110] != 2'b00 ||
          last != want.last || trunc != want.cut) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: piece mismatch, expected chunk %0d offset %0d len %0d last %0b cut %0b",
                   $realtime, want.chunk, want.inset, want.len, want.last, want.cut);
          $display("%0t:                 got chunk %0d offset %0d len %0d last %0b cut %0b pad %0b",
                   $realtime, data[47:0], data[78:48], data[109:79], last, trunc,
                   data[111:110]);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CHUNK_W-1:0]    cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [47:0] start_offset, [95:48] range_length
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [47:0] chunk_number, [78:48] offset_in_chunk,
                                               // [109:79] piece_length, [111:110] zero
  logic                  m_axis_tlast;         // last_piece
  logic [0:0]            m_axis_tuser;         // [0] truncated

  piece_ledger ledger;
  bit [30:0]   chunk_reg = CHUNK_RESET;  // our copy of the chunk size register
  bit          quiet;                    // when set, neither side idles nor stalls

  byte_range_chunk_splitter_core #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic bit [47:0] rand48();
    return {16'($urandom_range(0, 65535)), 32'($urandom)};
  endfunction

  // The chunk size that the core actually works with: zero acts as one.
  function automatic bit [63:0] effective_size();
    return (chunk_reg == '0) ? 64'd1 : {33'd0, chunk_reg};
  endfunction

  // Presents one request and holds it until the core takes it. The valid is
  // only lowered when a gap follows, so that it never drops and rises within
  // one time step between back-to-back transactions.
  task automatic send_request(bit [47:0] start, bit [47:0] span);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {span, start};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    ledger.note_request(start, span, chunk_reg);
  endtask

  // Writes the chunk size. Only called while the core is idle.
  task automatic write_chunk_size(bit [30:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chunk_reg = value;
  endtask

  // Stops sending, waits for every expected piece and then lets the division
  // of a request that yields no piece at all run out as well.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A random request. Most are short ranges around chunk boundaries; the rest
  // are empty ranges, ranges near the piece limit and fully random fields.
  task automatic random_request();
    bit [63:0]   size;
    bit [63:0]   base;
    bit [63:0]   span;
    bit [63:0]   mult;
    int unsigned mode;
    size = effective_size();
    mode = $urandom_range(0, 99);
    base = {16'd0, rand48()} / size;
    if (base > 0) begin
      base = base - 1;
    end
    base = base * size;
    if (mode < 12) begin
      send_request(rand48(), rand48());
    end else if (mode < 24) begin
      // Empty range, either on a boundary or just past one.
      if (size > 1 && $urandom_range(0, 1)) begin
        base = base + 64'($urandom_range(1, 32'(size - 1)));
      end
      send_request(base[47:0], 48'd0);
    end else if (mode < 38) begin
      mult = 64'($urandom_range(60, 68));
      span = mult * size + 64'($urandom_range(0, 32'(size - 1))) - size / 2;
      send_request(base[47:0] + 48'($urandom_range(0, 32'(size - 1))), span[47:0]);
    end else begin
      mult = 64'($urandom_range(0, 6));
      span = mult * size + 64'($urandom_range(0, 32'(size)));
      if ($urandom_range(0, 1)) begin
        base = 64'($urandom_range(0, 32'(size - 1))) + size * 64'($urandom_range(0, 3));
      end else begin
        base = base + 64'($urandom_range(0, 32'(size - 1)));
      end
      send_request(base[47:0], span[47:0]);
    end
  endtask

  // Result side: checks every piece taken and stalls at random.
  initial begin : piece_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        ledger.check_piece(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    bit [30:0]   plan [0:NUM_PHASES-1];
    bit [63:0]   size;
    bit [63:0]   start;
    int unsigned phase;
    ledger = new();
    // The first phase runs on the reset value; the rest cover the smallest
    // size, zero (acting as one), the largest values and a few in between.
    plan = '{CHUNK_RESET, 31'd1, 31'd0, 31'h7FFF_FFFF, 31'd2147483646,
             31'd3, 31'd4096, 31'd0, 31'd65536, 31'd1000000};
    plan[7] = 31'($urandom_range(2, 2147483646));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      quiet = (phase % 3 == 2);
      if (phase != 0) begin
        settle();
        write_chunk_size(plan[phase]);
      end
      size = effective_size();
      if (phase < 8) begin
        // Empty range on a boundary, then both fields at their maximum (cut at
        // the piece limit, and wrapping chunk numbers when the size is one),
        // then an empty range on the last byte of a chunk.
        send_request(48'd0, 48'd0);
        send_request(OFF_MAX, OFF_MAX);
        start = size * 5 + ((size > 1) ? size - 1 : 64'd0);
        send_request(start[47:0], 48'd0);
      end
      repeat (30) random_request();
    end
    settle();
    $display("Sent %0d requests over %0d chunk sizes and checked %0d pieces.",
             ledger.requests, NUM_PHASES, ledger.pieces_seen);
    $display("%0d requests were cut at the piece limit, %0d pieces were empty.",
             ledger.cut_requests, ledger.empty_pieces);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d pieces never arrived.",
               ledger.mismatches, ledger.outstanding());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("Timed out with %0d pieces still expected.", ledger.outstanding());
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
rtl/brcs_pkg.sv
rtl/byte_range_chunk_splitter_core.sv
rtl/brcs_checker.sv
test/byte_range_chunk_splitter_core_test.sv
